// ----- hdl/hfb_pkg.sv -----
`timescale 1ns / 1ps
package hfb_pkg;

    localparam logic [2:0] OP_INIT     = 3'd0;
    localparam logic [2:0] OP_SET      = 3'd1;
    localparam logic [2:0] OP_CLEAR    = 3'd2;
    localparam logic [2:0] OP_GET      = 3'd3;
    localparam logic [2:0] OP_FIND     = 3'd4;
    localparam logic [2:0] OP_FIND_SET = 3'd5;

    localparam logic [15:0] WORD_FULL = 16'hffff;
    localparam logic [31:0] TOP_FULL  = 32'hffffffff;

    // lowest zero bit of a 16-bit word, 16 when none
    function automatic logic [4:0] first_free16(input logic [15:0] w);
        logic [4:0] pos;
        pos = 5'd16;
        for (int i = 15; i >= 0; i--) begin
            if (!w[i]) pos = 5'(i);
        end
        return pos;
    endfunction

    // lowest zero bit of a 32-bit word, 32 when none
    function automatic logic [5:0] first_free32(input logic [31:0] w);
        logic [5:0] pos;
        pos = 6'd32;
        for (int i = 31; i >= 0; i--) begin
            if (!w[i]) pos = 6'(i);
        end
        return pos;
    endfunction

    // init value of row entry idx for a length with quotient q and remainder r
    function automatic logic [15:0] fill_word(input logic [9:0] q, input logic [3:0] r,
                                              input logic [9:0] idx);
        logic [15:0] w;
        if (idx < q) w = 16'h0000;
        else if (idx == q) w = WORD_FULL << r;
        else w = WORD_FULL;
        return w;
    endfunction

    function automatic logic [31:0] top_mask(input logic [5:0] len);
        logic [31:0] w;
        if (len >= 6'd32) w = 32'h0;
        else w = TOP_FULL << len;
        return w;
    endfunction

endpackage

// ----- hdl/hfb_ram.sv -----
`timescale 1ns / 1ps
module hfb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- hdl/hierarchical_free_bitmap_top.sv -----
`timescale 1ns / 1ps
// an accepted beat that touches only the top word, or errors, goes straight to the
// result state; set/clear/get first read the leaf and mid words together, and a find
// reads the mid word and then the leaf word, since each memory has one read port;
// init over more than 32 items sweeps both memories. one item in flight at a time.
// reset (synchronous, active low) sets item_count to 8192 and runs the same
// init sweep, with o_stall high, before the first beat.
module hierarchical_free_bitmap_top
    import hfb_pkg::*;
#(
    parameter int MAX_ITEMS = 8192
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [13:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_operation,
    input  logic [12:0] i_item_index,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_bit_value,
    output logic [12:0] o_found_index,
    output logic        o_map_full,
    output logic        o_index_error
);

    localparam int LEAF_WORDS = (MAX_ITEMS + 15) / 16;
    localparam int MID_WORDS  = (LEAF_WORDS + 15) / 16;
    localparam int LEAF_AW    = (LEAF_WORDS > 1) ? $clog2(LEAF_WORDS) : 1;
    localparam int MID_AW     = (MID_WORDS > 1) ? $clog2(MID_WORDS) : 1;

    typedef enum logic [2:0] {S_IDLE, S_INIT, S_ISSUE, S_MIDX, S_FIN} t_state;

    t_state              r_state;
    t_state              n_issue_state;
    logic [2:0]          r_op;
    logic [12:0]         r_idx;
    logic [13:0]         r_n;
    logic [13:0]         r_item_count;
    logic [LEAF_AW-1:0]  r_cnt;
    logic                r_silent;
    logic [31:0]         r_top;

    logic [13:0] eff_n;
    logic        lvl;
    logic [9:0]  leaf_len;
    logic [5:0]  top_len;
    logic [31:0] init_top;
    logic        out_free;
    logic        is_find;

    logic [15:0] leaf_q, mid_q;
    logic [5:0]  tb;
    logic        mid_ok;
    logic [4:0]  fm;
    logic [8:0]  fwl;
    logic        leaf_ok;
    logic [4:0]  fl;
    logic [12:0] item;
    logic        find_full;

    logic        idx_err;
    logic [15:0] bl, bm;
    logic [31:0] bt_idx, bt_find, tbit;

    logic                leaf_we, leaf_re, mid_we, mid_re;
    logic [LEAF_AW-1:0]  leaf_wa, leaf_ra;
    logic [MID_AW-1:0]   mid_wa, mid_ra;
    logic [15:0]         leaf_wd, mid_wd;
    logic [31:0]         n_top;
    logic                n_bit, n_full;
    logic [12:0]         n_found;

    assign eff_n    = (r_item_count > 14'(MAX_ITEMS)) ? 14'(MAX_ITEMS) : r_item_count;
    assign lvl      = r_n > 14'd32;
    assign leaf_len = 10'((15'(r_n) + 15'd15) >> 4);
    assign top_len  = lvl ? 6'((11'(leaf_len) + 11'd15) >> 4) : r_n[5:0];
    assign init_top = top_mask(top_len);
    assign out_free = !o_valid || !i_stall;
    assign is_find  = (r_op == OP_FIND) || (r_op == OP_FIND_SET);
    assign o_stall  = (r_state != S_IDLE);

    // where an accepted beat goes first
    always_comb begin
        n_issue_state = S_FIN;
        if (eff_n > 14'd32) begin
            case (i_operation) inside
                OP_INIT: n_issue_state = S_INIT;
                OP_SET, OP_CLEAR, OP_GET: begin
                    if ({1'b0, i_item_index} < eff_n) n_issue_state = S_ISSUE;
                end
                OP_FIND, OP_FIND_SET: n_issue_state = S_ISSUE;
                default: ;
            endcase
        end
    end

    // find path: top -> mid -> leaf
    assign tb      = first_free32(r_top);
    assign mid_ok  = !tb[5] && (tb < 6'(MID_WORDS));
    assign fm      = first_free16(mid_q);
    assign fwl     = {tb[4:0], fm[3:0]};
    assign leaf_ok = mid_ok && !fm[4] && ({1'b0, fwl} < 10'(LEAF_WORDS));
    assign fl      = first_free16(leaf_q);
    assign item    = {fwl, fl[3:0]};
    always_comb begin
        if (lvl) begin
            find_full = !leaf_ok || fl[4] || ({1'b0, item} >= r_n);
        end else begin
            find_full = tb[5] || (14'(tb) >= r_n);
        end
    end

    assign idx_err = ({1'b0, r_idx} >= r_n);
    assign bl      = 16'(1) << r_idx[3:0];
    assign bm      = 16'(1) << r_idx[7:4];
    assign bt_idx  = 32'(1) << r_idx[12:8];
    assign bt_find = 32'(1) << tb[4:0];
    assign tbit    = 32'(1) << r_idx[4:0];

    // memory port control
    always_comb begin
        leaf_re = 1'b0;
        mid_re  = 1'b0;
        leaf_ra = r_idx[LEAF_AW+3:4];
        mid_ra  = is_find ? tb[MID_AW-1:0] : r_idx[MID_AW+7:8];
        if (r_state == S_ISSUE) begin
            leaf_re = !is_find;
            mid_re  = is_find ? mid_ok : 1'b1;
        end else if (r_state == S_MIDX) begin
            leaf_ra = fwl[LEAF_AW-1:0];
            leaf_re = leaf_ok;
        end
    end

    always_comb begin
        leaf_we = 1'b0;
        mid_we  = 1'b0;
        leaf_wa = is_find ? fwl[LEAF_AW-1:0] : r_idx[LEAF_AW+3:4];
        mid_wa  = mid_ra;
        leaf_wd = leaf_q;
        mid_wd  = mid_q;
        n_top   = r_top;
        n_bit   = 1'b0;
        n_full  = 1'b0;
        n_found = 13'd0;
        if (r_state == S_INIT) begin
            leaf_we = 1'b1;
            leaf_wa = r_cnt;
            leaf_wd = fill_word(r_n[13:4], r_n[3:0], 10'(r_cnt));
            mid_we  = (10'(r_cnt) < 10'(MID_WORDS));
            mid_wa  = r_cnt[MID_AW-1:0];
            mid_wd  = fill_word({4'd0, leaf_len[9:4]}, leaf_len[3:0], 10'(r_cnt));
        end else if (r_state == S_FIN && out_free) begin
            case (r_op) inside
                OP_INIT: n_top = init_top;
                OP_SET, OP_CLEAR, OP_GET: begin
                    if (!idx_err) begin
                        if (!lvl) begin
                            if (r_op == OP_SET) n_top = r_top | tbit;
                            else if (r_op == OP_CLEAR) n_top = r_top & ~tbit;
                            else n_bit = r_top[r_idx[4:0]];
                        end else if (r_op == OP_SET) begin
                            leaf_we = 1'b1;
                            leaf_wd = leaf_q | bl;
                            mid_wd  = mid_q | bm;
                            mid_we  = (leaf_wd == WORD_FULL);
                            if (mid_we && mid_wd == WORD_FULL) n_top = r_top | bt_idx;
                        end else if (r_op == OP_CLEAR) begin
                            leaf_we = 1'b1;
                            leaf_wd = leaf_q & ~bl;
                            mid_we  = (leaf_q == WORD_FULL);
                            mid_wd  = mid_q & ~bm;
                            if (mid_we && mid_q == WORD_FULL) n_top = r_top & ~bt_idx;
                        end else begin
                            n_bit = leaf_q[r_idx[3:0]];
                        end
                    end
                end
                OP_FIND, OP_FIND_SET: begin
                    n_full = find_full;
                    if (!find_full) begin
                        n_found = lvl ? item : 13'(tb);
                        if (r_op == OP_FIND_SET) begin
                            if (!lvl) begin
                                n_top = r_top | bt_find;
                            end else begin
                                leaf_we = 1'b1;
                                leaf_wd = leaf_q | (16'(1) << fl[3:0]);
                                mid_wd  = mid_q | (16'(1) << fm[3:0]);
                                mid_we  = (leaf_wd == WORD_FULL);
                                if (mid_we && mid_wd == WORD_FULL) n_top = r_top | bt_find;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    hfb_ram #(.WIDTH(16), .DEPTH(LEAF_WORDS)) u_leaf_ram (
        .i_clk     (i_clk),
        .i_wr_en   (leaf_we),
        .i_wr_addr (leaf_wa),
        .i_wr_data (leaf_wd),
        .i_rd_en   (leaf_re),
        .i_rd_addr (leaf_ra),
        .o_rd_data (leaf_q)
    );

    hfb_ram #(.WIDTH(16), .DEPTH(MID_WORDS)) u_mid_ram (
        .i_clk     (i_clk),
        .i_wr_en   (mid_we),
        .i_wr_addr (mid_wa),
        .i_wr_data (mid_wd),
        .i_rd_en   (mid_re),
        .i_rd_addr (mid_ra),
        .o_rd_data (mid_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_INIT;
            r_op          <= OP_INIT;
            r_item_count  <= 14'd8192;
            r_n           <= (MAX_ITEMS > 8192) ? 14'd8192 : 14'(MAX_ITEMS);
            r_cnt         <= '0;
            r_silent      <= 1'b1;
            r_top         <= TOP_FULL;
            o_valid       <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_item_count <= i_cfg_wr_data;
            end
            if (o_valid && !i_stall && r_state != S_FIN) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op     <= i_operation;
                        r_idx    <= i_item_index;
                        r_n      <= eff_n;
                        r_cnt    <= '0;
                        r_silent <= 1'b0;
                        r_state  <= n_issue_state;
                    end
                end
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LEAF_AW'(LEAF_WORDS - 1)) begin
                        r_top   <= init_top;
                        r_state <= r_silent ? S_IDLE : S_FIN;
                    end
                end
                S_ISSUE: r_state <= is_find ? S_MIDX : S_FIN;
                S_MIDX:  r_state <= S_FIN;
                S_FIN: begin
                    // hold here while the previous result is still waiting
                    if (out_free) begin
                        r_top         <= n_top;
                        o_valid       <= 1'b1;
                        o_bit_value   <= n_bit;
                        o_found_index <= n_found;
                        o_map_full    <= n_full;
                        o_index_error <= (r_op == OP_SET || r_op == OP_CLEAR ||
                                          r_op == OP_GET) && idx_err;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- sim/hierarchical_free_bitmap_top_tb.sv -----
`timescale 1ns / 1ps
module hierarchical_free_bitmap_top_tb
    import hfb_pkg::*;
();

    localparam int NUM_LEAF = 512;
    localparam int NUM_MID = 32;
    localparam int IDLE_LIMIT = 20000;

    typedef struct packed {
        logic        bit_value;
        logic [12:0] found_index;
        logic        map_full;
        logic        index_error;
    } t_alloc_result;

    class alloc_scoreboard;
        logic [31:0] top_bits;
        logic [15:0] mid_bits[NUM_MID];
        logic [15:0] leaf_bits[NUM_LEAF];
        int unsigned count_cfg;
        t_alloc_result pending[$];
        int mismatches;

        function int unsigned eff_count();
            return (count_cfg > 8192) ? 8192 : count_cfg;
        endfunction

        function int unsigned lowest_free(logic [31:0] w, int unsigned width);
            for (int i = 0; i < width; i++) if (!w[i]) return i;
            return width;
        endfunction

        function logic [15:0] row_word(int unsigned n, int unsigned i);
            if (i < n / 16) return 16'h0000;
            if (i == n / 16) return 16'hffff << (n % 16);
            return 16'hffff;
        endfunction

        function void rebuild();
            int unsigned n, top_len, leaf_len;
            n = eff_count();
            top_len = n;
            if (n > 32) begin
                leaf_len = (n + 15) / 16;
                for (int i = 0; i < NUM_LEAF; i++) leaf_bits[i] = row_word(n, i);
                for (int i = 0; i < NUM_MID; i++) mid_bits[i] = row_word(leaf_len, i);
                top_len = (leaf_len + 15) / 16;
            end
            top_bits = (top_len >= 32) ? 32'h0 : (32'hffffffff << top_len);
        endfunction

        function new();
            count_cfg = 8192;
            mismatches = 0;
            rebuild();
        endfunction

        function void note_beat(logic [2:0] op, logic [12:0] k);
            t_alloc_result r;
            int unsigned n, wl, wm, bt, bm, bl, item;
            logic [15:0] nl, nm;
            r = '0;
            n = eff_count();
            if (op == OP_INIT) begin
                rebuild();
            end else if (op == OP_SET || op == OP_CLEAR || op == OP_GET) begin
                if (k >= n) begin
                    r.index_error = 1'b1;
                end else if (n <= 32) begin
                    if (op == OP_SET) top_bits[k[4:0]] = 1'b1;
                    else if (op == OP_CLEAR) top_bits[k[4:0]] = 1'b0;
                    else r.bit_value = top_bits[k[4:0]];
                end else begin
                    wl = k / 16;
                    wm = wl / 16;
                    if (op == OP_SET) begin
                        nl = leaf_bits[wl] | (16'h1 << (k % 16));
                        if (nl == 16'hffff) begin
                            nm = mid_bits[wm] | (16'h1 << (wl % 16));
                            if (nm == 16'hffff) top_bits[wm] = 1'b1;
                            mid_bits[wm] = nm;
                        end
                        leaf_bits[wl] = nl;
                    end else if (op == OP_CLEAR) begin
                        if (leaf_bits[wl] == 16'hffff) begin
                            if (mid_bits[wm] == 16'hffff) top_bits[wm] = 1'b0;
                            mid_bits[wm][wl % 16] = 1'b0;
                        end
                        leaf_bits[wl][k % 16] = 1'b0;
                    end else begin
                        r.bit_value = leaf_bits[wl][k % 16];
                    end
                end
            end else if (op == OP_FIND || op == OP_FIND_SET) begin
                bt = lowest_free(top_bits, 32);
                if (bt >= 32) begin
                    r.map_full = 1'b1;
                end else if (n <= 32) begin
                    if (bt >= n) r.map_full = 1'b1;
                    else begin
                        r.found_index = 13'(bt);
                        if (op == OP_FIND_SET) top_bits[bt] = 1'b1;
                    end
                end else if (bt >= NUM_MID) begin
                    r.map_full = 1'b1;
                end else begin
                    bm = lowest_free({16'hffff, mid_bits[bt]}, 16);
                    wl = bt * 16 + bm;
                    bl = (bm < 16 && wl < NUM_LEAF)
                         ? lowest_free({16'hffff, leaf_bits[wl]}, 16) : 16;
                    item = wl * 16 + bl;
                    if (bl >= 16 || item >= n) begin
                        r.map_full = 1'b1;
                    end else begin
                        r.found_index = 13'(item);
                        if (op == OP_FIND_SET) begin
                            nl = leaf_bits[wl] | (16'h1 << bl);
                            if (nl == 16'hffff) begin
                                nm = mid_bits[bt] | (16'h1 << bm);
                                if (nm == 16'hffff) top_bits[bt] = 1'b1;
                                mid_bits[bt] = nm;
                            end
                            leaf_bits[wl] = nl;
                        end
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_result(t_alloc_result got);
            t_alloc_result exp;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: %p", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch: expected bit=%0d idx=%0d full=%0d err=%0d, ",
                              "got bit=%0d idx=%0d full=%0d err=%0d"},
                             exp.bit_value, exp.found_index, exp.map_full, exp.index_error,
                             got.bit_value, got.found_index, got.map_full, got.index_error);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [13:0] cfg_wr_data;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  operation;
    logic [12:0] item_index;
    logic        out_valid;
    logic        out_stall;
    logic        bit_value;
    logic [12:0] found_index;
    logic        map_full;
    logic        index_error;

    alloc_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    bit timed_out;

    hierarchical_free_bitmap_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (in_valid),
        .o_stall       (in_stall),
        .i_operation   (operation),
        .i_item_index  (item_index),
        .o_valid       (out_valid),
        .i_stall       (out_stall),
        .o_bit_value   (bit_value),
        .o_found_index (found_index),
        .o_map_full    (map_full),
        .o_index_error (index_error)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // receiver side: random stall, check on accepted beat
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result({bit_value, found_index, map_full, index_error});
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog on accepted beats
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    // valid stays high after the accepting edge until the next call or drain
    task automatic send_beat(input logic [2:0] op, input logic [12:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        item_index <= k;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_beat(op, k);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        // quiet clocks before touching config
        repeat (4) @(posedge clk);
    endtask

    task automatic write_count(input logic [13:0] n);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= n;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.count_cfg = n;
    endtask

    function automatic logic [12:0] pick_index();
        int unsigned n;
        n = sb.eff_count();
        if ($urandom_range(9) == 0 || n == 0) return 13'($urandom);
        return 13'($urandom_range(n - 1));
    endfunction

    task automatic run_random(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 2) send_beat(OP_INIT, 13'($urandom));
            else if (r < 30) send_beat(OP_FIND_SET, 13'($urandom));
            else if (r < 40) send_beat(OP_FIND, 13'($urandom));
            else if (r < 60) send_beat(OP_CLEAR, pick_index());
            else if (r < 75) send_beat(OP_SET, pick_index());
            else if (r < 97) send_beat(OP_GET, pick_index());
            else send_beat(3'($urandom_range(6, 7)), 13'($urandom));
        end
    endtask

    initial begin
        logic [13:0] counts[6];
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        in_valid = 1'b0;
        operation = OP_INIT;
        item_index = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full size extremes
        send_beat(OP_GET, 13'd0);
        send_beat(OP_GET, 13'd8191);
        send_beat(OP_FIND, 13'd0);
        send_beat(OP_FIND_SET, 13'd0);
        send_beat(OP_SET, 13'd8191);
        send_beat(OP_GET, 13'd8191);
        send_beat(OP_CLEAR, 13'd0);
        send_beat(OP_FIND_SET, 13'h1555);
        send_beat(3'd6, 13'h0aaa);
        send_beat(3'd7, 13'h1fff);
        for (int i = 0; i < 16; i++) send_beat(OP_SET, 13'(i));
        send_beat(OP_FIND, 13'd0);
        send_beat(OP_CLEAR, 13'd5);
        send_beat(OP_FIND, 13'd0);
        // zero items: gets error and finds are full
        write_count(14'd0);
        send_beat(OP_INIT, 13'd0);
        send_beat(OP_GET, 13'd0);
        send_beat(OP_FIND_SET, 13'd0);
        // count beyond max, and change without init
        write_count(14'h3fff);
        send_beat(OP_FIND, 13'd0);
        send_beat(OP_INIT, 13'd0);
        write_count(14'd40);
        send_beat(OP_FIND_SET, 13'd0);
        send_beat(OP_GET, 13'd39);

        counts = '{14'd1, 14'd32, 14'd33, 14'd40, 14'd300, 14'd8192};
        for (int ph = 0; ph < 6; ph++) begin
            write_count(ph == 1 ? 14'($urandom_range(2, 31)) : counts[ph]);
            send_beat(OP_INIT, 13'd0);
            case (ph % 4)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 79; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 79; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            // small maps fill up fast, so finds hit full too
            run_random(ph == 5 ? 400 : 190);
            if (ph == 2) drain();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
        drain();

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/hfb_pkg.sv
hdl/hfb_ram.sv
hdl/hierarchical_free_bitmap_top.sv
sim/hierarchical_free_bitmap_top_tb.sv
